// ===== sv/double_ended_indexed_array_assert.svh =====
// ---------------------------------------------------------------------------
// double_ended_indexed_array_assert
// Assertion macros for the double-ended indexed array
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_INDEXED_ARRAY_ASSERT_SVH
`define DOUBLE_ENDED_INDEXED_ARRAY_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DEA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define DEA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define DEA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DEA_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== sv/dea_pkg.sv =====
// ---------------------------------------------------------------------------
// dea_pkg
// Shared constants, operation codes and control structs of the
// double-ended indexed array
// ---------------------------------------------------------------------------
package dea_pkg;

  localparam int DEA_CAPACITY   = 256;
  localparam int DEA_WORD_WIDTH = 32;

  localparam int FUNC_W  = 4;
  localparam int INDEX_W = 8;
  localparam int VALUE_W = 32;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 9;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_BACK  = 4'd0,
    FN_PUSH_FRONT = 4'd1,
    FN_POP_BACK   = 4'd2,
    FN_POP_FRONT  = 4'd3,
    FN_PEEK_BACK  = 4'd4,
    FN_PEEK_FRONT = 4'd5,
    FN_GET        = 4'd6,
    FN_SET        = 4'd7,
    FN_CLEAR      = 4'd8
  } func_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // register the input beat
    logic exec;     // memory access and state update
    logic capture;  // move the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy; // output register holds a beat that is not taken this cycle
  } sts_t;

endpackage

// ===== sv/dea_ctrl.sv =====
// ---------------------------------------------------------------------------
// dea_ctrl
// Sequencer: accept, execute, capture result
// ---------------------------------------------------------------------------
module dea_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  dea_pkg::sts_t sts,
  output dea_pkg::cmd_t cmd
);
  import dea_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_CAPT = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_CAPT;
      end
      ST_CAPT: begin
        // wait for the previous result to leave the output register
        if (!sts.out_busy) begin
          cmd.capture = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/dea_datapath.sv =====
// ---------------------------------------------------------------------------
// dea_datapath
// Ring storage, front pointer, fill count and output register
// ---------------------------------------------------------------------------
module dea_datapath #(
  parameter int CAPACITY   = dea_pkg::DEA_CAPACITY,
  parameter int WORD_WIDTH = dea_pkg::DEA_WORD_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dea_pkg::cmd_t                cmd,
  output dea_pkg::sts_t                sts,
  input  logic [dea_pkg::FUNC_W-1:0]   func,
  input  logic [dea_pkg::INDEX_W-1:0]  index,
  input  logic [dea_pkg::VALUE_W-1:0]  value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dea_pkg::DATA_W-1:0]   data,
  output logic                         ok,
  output logic [dea_pkg::COUNT_W-1:0]  count,
  output logic                         empty_res
);
  import dea_pkg::*;

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // operand registers
  logic [FUNC_W-1:0]  op_func;
  logic [INDEX_W-1:0] op_index;
  logic [VALUE_W-1:0] op_value;

  // queue state
  logic [CW-1:0]         fill_count, fill_count_next;
  logic [PW-1:0]         front_ptr, front_ptr_next;
  logic [WORD_WIDTH-1:0] mem [CAPACITY];
  logic [WORD_WIDTH-1:0] rd_word;
  logic                  ok_q;
  logic                  rd_q;

  logic [31:0]           fill_wide;
  logic [31:0]           logical;
  logic [31:0]           place_sum;
  logic [31:0]           place_wrap;
  logic [PW-1:0]         front_dec;
  logic [PW-1:0]         front_inc;
  logic [PW-1:0]         addr;
  logic                  use_front_dec;
  logic                  hit;
  logic                  rd_hit;
  logic                  wr_en;
  logic                  full;
  logic                  is_empty;
  logic [63:0]           value_wide;
  logic [WORD_WIDTH-1:0] wr_word;
  logic [63:0]           rd_wide;
  logic [31:0]           count_wide;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func  <= func;
      op_index <= index;
      op_value <= value;
    end
  end

  assign fill_wide = 32'(fill_count);
  assign full      = (fill_wide == 32'(CAPACITY));
  assign is_empty  = (fill_count == '0);

  assign front_dec = (front_ptr == '0) ? PW'(CAPACITY - 1) : front_ptr - PW'(1);
  assign front_inc = (32'(front_ptr) + 32'd1 == 32'(CAPACITY)) ? '0 : front_ptr + PW'(1);

  // logical position to ring place, one compare and subtract
  assign place_sum  = 32'(front_ptr) + logical;
  assign place_wrap = (place_sum >= 32'(CAPACITY)) ? place_sum - 32'(CAPACITY) : place_sum;
  assign addr       = use_front_dec ? front_dec : place_wrap[PW-1:0];

  assign value_wide = 64'(op_value);
  assign wr_word    = value_wide[WORD_WIDTH-1:0];

  always_comb begin
    hit             = 1'b0;
    rd_hit          = 1'b0;
    wr_en           = 1'b0;
    use_front_dec   = 1'b0;
    logical         = '0;
    fill_count_next = fill_count;
    front_ptr_next  = front_ptr;
    unique case (func_t'(op_func))
      FN_PUSH_BACK: begin
        logical = fill_wide;
        if (!full) begin
          hit             = 1'b1;
          wr_en           = 1'b1;
          fill_count_next = fill_count + CW'(1);
        end
      end
      FN_PUSH_FRONT: begin
        use_front_dec = 1'b1;
        if (!full) begin
          hit             = 1'b1;
          wr_en           = 1'b1;
          front_ptr_next  = front_dec;
          fill_count_next = fill_count + CW'(1);
        end
      end
      FN_POP_BACK: begin
        logical = fill_wide - 32'd1;
        if (!is_empty) begin
          hit             = 1'b1;
          rd_hit          = 1'b1;
          fill_count_next = fill_count - CW'(1);
        end
      end
      FN_POP_FRONT: begin
        if (!is_empty) begin
          hit             = 1'b1;
          rd_hit          = 1'b1;
          front_ptr_next  = front_inc;
          fill_count_next = fill_count - CW'(1);
        end
      end
      FN_PEEK_BACK: begin
        logical = fill_wide - 32'd1;
        if (!is_empty) begin
          hit    = 1'b1;
          rd_hit = 1'b1;
        end
      end
      FN_PEEK_FRONT: begin
        if (!is_empty) begin
          hit    = 1'b1;
          rd_hit = 1'b1;
        end
      end
      FN_GET: begin
        logical = 32'(op_index);
        if (32'(op_index) < fill_wide) begin
          hit    = 1'b1;
          rd_hit = 1'b1;
        end
      end
      FN_SET: begin
        logical = 32'(op_index);
        if (32'(op_index) < fill_wide) begin
          hit   = 1'b1;
          wr_en = 1'b1;
        end
      end
      FN_CLEAR: begin
        hit             = 1'b1;
        fill_count_next = '0;
        front_ptr_next  = '0;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      front_ptr  <= '0;
    end else if (cmd.exec) begin
      fill_count <= fill_count_next;
      front_ptr  <= front_ptr_next;
    end
  end

  // single-port ring storage, registered read
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (wr_en) begin
        mem[addr] <= wr_word;
      end
      rd_word <= mem[addr];
      ok_q    <= hit;
      rd_q    <= rd_hit;
    end
  end

  assign rd_wide    = 64'(rd_word);
  assign count_wide = 32'(fill_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.capture) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      data      <= rd_q ? rd_wide[DATA_W-1:0] : '0;
      ok        <= ok_q;
      count     <= count_wide[COUNT_W-1:0];
      empty_res <= is_empty;
    end
  end

  assign sts.out_busy = out_valid && out_stall;

endmodule

// ===== sv/double_ended_indexed_array.sv =====
// ---------------------------------------------------------------------------
// double_ended_indexed_array
// Double-ended queue of words with random access by logical index
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries func, index and value; one
//   beat asks for one operation: push, pop or peek at either end, get or
//   set at a logical index, or clear. Output channel (out_valid /
//   out_stall) returns one beat per operation with data, ok, count and
//   empty_res.
//   Each beat runs through accept, access and capture in turn, with capture
//   held while the output register still holds an untaken beat. A new
//   operation is not taken before the previous one is captured, as the ring
//   storage has a single port with a registered read.
//   A new operation is taken while the previous result still waits in the
//   output register; if the receiver keeps stalling, the following result
//   waits in the datapath and in_stall stays high until it can move on.
//   Reset empties the queue (count and front pointer to zero); the storage
//   itself is not cleared and no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "double_ended_indexed_array_assert.svh"

module double_ended_indexed_array #(
  parameter int CAPACITY   = dea_pkg::DEA_CAPACITY,
  parameter int WORD_WIDTH = dea_pkg::DEA_WORD_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [dea_pkg::FUNC_W-1:0]   func,
  input  logic [dea_pkg::INDEX_W-1:0]  index,
  input  logic [dea_pkg::VALUE_W-1:0]  value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dea_pkg::DATA_W-1:0]   data,
  output logic                         ok,
  output logic [dea_pkg::COUNT_W-1:0]  count,
  output logic                         empty_res
);
  import dea_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dea_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dea_datapath #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .func      (func),
    .index     (index),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data      (data),
    .ok        (ok),
    .count     (count),
    .empty_res (empty_res)
  );

  `DEA_ASSERT_NXT(a_accept_then_exec, clk, rst, in_valid && !in_stall, cmd.exec)
  `DEA_ASSERT_IMP(a_fail_zero_data, clk, rst, out_valid && !ok, data == '0)
  `DEA_ASSERT_IMP(a_valid_from_capture, clk, rst, $rose(out_valid), $past(cmd.capture))

endmodule

// ===== tb/double_ended_indexed_array_tb.sv =====
// ---------------------------------------------------------------------------
// double_ended_indexed_array_tb
// Self-checking bench for the double-ended indexed array: a directed run
// over empty, boundary and unused-code cases, then randomized pushes, pops,
// peeks, indexed reads and writes and clears, with one pass that fills the
// store to capacity. A scoreboard keeps its own ring and fill count, works
// out the reply to each accepted beat and compares every returned beat in
// order. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module double_ended_indexed_array_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dea_pkg::*;

  localparam int CAP       = DEA_CAPACITY;
  localparam int UNUSED_LO = int'(FN_CLEAR) + 1;
  localparam int UNUSED_HI = (1 << FUNC_W) - 1;
  localparam int N_ITEMS   = 600;
  localparam int MAX_SHOWN = 20;

  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic               ok;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
  } reply_t;

  class dea_scoreboard;
    logic [DATA_W-1:0] ring [CAP];
    logic [COUNT_W-1:0] fill;
    logic [INDEX_W-1:0] head;
    reply_t replies_due[$];
    int n_ops, n_checked, n_err, n_full, n_refused, n_out_of_range, n_clears;

    function new();
      fill = '0;
      head = '0;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    // work out the reply to one accepted beat and update the shadow store
    function void take_op(logic [FUNC_W-1:0] f, logic [INDEX_W-1:0] idx,
                          logic [VALUE_W-1:0] val);
      reply_t r;
      r = '0;
      n_ops++;
      case (f)
        FN_PUSH_BACK, FN_PUSH_FRONT: begin
          if (fill < CAP) begin
            if (f == FN_PUSH_BACK) begin
              ring[INDEX_W'(head + fill[INDEX_W-1:0])] = val;
            end else begin
              head = head - 1'b1;
              ring[head] = val;
            end
            fill++;
            r.ok = 1'b1;
            if (fill == CAP) n_full++;
          end else begin
            n_refused++;
          end
        end
        FN_POP_BACK, FN_PEEK_BACK: begin
          if (fill != 0) begin
            r.data = ring[INDEX_W'(head + fill[INDEX_W-1:0] - 1'b1)];
            r.ok = 1'b1;
            if (f == FN_POP_BACK) fill--;
          end
        end
        FN_POP_FRONT, FN_PEEK_FRONT: begin
          if (fill != 0) begin
            r.data = ring[head];
            r.ok = 1'b1;
            if (f == FN_POP_FRONT) begin
              head = head + 1'b1;
              fill--;
            end
          end
        end
        FN_GET, FN_SET: begin
          if (idx < fill) begin
            if (f == FN_GET) r.data = ring[INDEX_W'(head + idx)];
            else ring[INDEX_W'(head + idx)] = val;
            r.ok = 1'b1;
          end else begin
            n_out_of_range++;
          end
        end
        FN_CLEAR: begin
          fill = '0;
          head = '0;
          r.ok = 1'b1;
          n_clears++;
        end
        default: ;
      endcase
      r.count = fill;
      r.is_empty = (fill == 0);
      replies_due.push_back(r);
    endfunction

    task report(string msg);
      n_err++;
      if (n_err <= MAX_SHOWN) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_reply(logic [DATA_W-1:0] d, logic k, logic [COUNT_W-1:0] c, logic e);
      reply_t x;
      if (replies_due.size() == 0) begin
        report($sformatf("result beat with nothing outstanding (data=%h)", d));
      end else begin
        x = replies_due.pop_front();
        n_checked++;
        if (d !== x.data) report($sformatf("data %h, want %h", d, x.data));
        if (k !== x.ok) report($sformatf("ok %b, want %b", k, x.ok));
        if (c !== x.count) report($sformatf("count %0d, want %0d", c, x.count));
        if (e !== x.is_empty) report($sformatf("empty_res %b, want %b", e, x.is_empty));
      end
    endtask
  endclass

  logic clk, rst;
  logic in_valid, in_stall;
  logic [FUNC_W-1:0] func;
  logic [INDEX_W-1:0] index;
  logic [VALUE_W-1:0] value;
  logic out_valid, out_stall;
  logic [DATA_W-1:0] data;
  logic ok;
  logic [COUNT_W-1:0] count;
  logic empty_res;

  dea_scoreboard sb = new();
  bit no_idle;
  int fill_shadow;
  int n_sent;

  double_ended_indexed_array u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .index     (index),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data      (data),
    .ok        (ok),
    .count     (count),
    .empty_res (empty_res)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.take_op(func, index, value);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_reply(data, ok, count, empty_res);
  end

  // receiver: stall a random number of cycles before each result beat
  initial begin
    int n;
    out_stall = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_op(logic [FUNC_W-1:0] f, logic [INDEX_W-1:0] idx,
                         logic [VALUE_W-1:0] val);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    index <= idx;
    value <= val;
    do @(posedge clk); while (in_stall);
    n_sent++;
    // generator-side fill estimate, only used to aim indexes
    case (f)
      FN_PUSH_BACK, FN_PUSH_FRONT: if (fill_shadow < CAP) fill_shadow++;
      FN_POP_BACK, FN_POP_FRONT:   if (fill_shadow > 0) fill_shadow--;
      FN_CLEAR:                    fill_shadow = 0;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [INDEX_W-1:0] pick_index();
    if (fill_shadow > 0 && $urandom_range(0, 4) != 0)
      return INDEX_W'($urandom_range(0, fill_shadow - 1));
    return INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
  endfunction

  task automatic mixed_op(int pop_bias);
    int r;
    logic [FUNC_W-1:0] f;
    r = $urandom_range(0, 99);
    if (r < pop_bias) f = $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
    else if (r < 20) f = FN_PUSH_BACK;
    else if (r < 35) f = FN_PUSH_FRONT;
    else if (r < 47) f = FN_POP_BACK;
    else if (r < 59) f = FN_POP_FRONT;
    else if (r < 65) f = FN_PEEK_BACK;
    else if (r < 71) f = FN_PEEK_FRONT;
    else if (r < 83) f = FN_GET;
    else if (r < 93) f = FN_SET;
    else if (r < 95) f = FN_CLEAR;
    else f = FUNC_W'($urandom_range(UNUSED_LO, UNUSED_HI));
    send_op(f, pick_index(), $urandom());
  endtask

  initial begin
    int r;
    rst = 1'b1;
    in_valid = 1'b0;
    func = '0;
    index = '0;
    value = '0;
    no_idle = 1'b0;
    fill_shadow = 0;
    n_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty store, unused code, then a few words at both ends
    send_op(FN_POP_BACK, '0, '0);
    send_op(FN_POP_FRONT, '0, '0);
    send_op(FN_PEEK_BACK, '0, '0);
    send_op(FN_PEEK_FRONT, '0, '0);
    send_op(FN_GET, '0, '0);
    send_op(FN_SET, '0, 32'h1234_5678);
    send_op(FUNC_W'(UNUSED_LO), '0, '1);
    send_op(FN_PUSH_BACK, '1, '1);
    send_op(FN_PUSH_FRONT, '0, '0);
    send_op(FN_PUSH_BACK, '0, 32'hA5A5_A5A5);
    send_op(FN_GET, 8'd0, '0);
    send_op(FN_GET, 8'd2, '0);
    send_op(FN_GET, 8'd3, '0);   // index equal to count
    send_op(FN_GET, '1, '0);
    send_op(FN_SET, 8'd1, 32'h5A5A_5A5A);
    send_op(FN_GET, 8'd1, '0);
    send_op(FN_PEEK_BACK, '0, '0);
    send_op(FN_PEEK_FRONT, '0, '0);
    send_op(FN_POP_FRONT, '0, '0);
    send_op(FN_POP_BACK, '0, '0);
    send_op(FUNC_W'(UNUSED_HI), '1, '1);
    send_op(FN_CLEAR, '0, '0);
    send_op(FN_PEEK_FRONT, '0, '0);
    send_op(FN_PUSH_FRONT, '0, 32'h8000_0001);
    send_op(FN_POP_BACK, '0, '0);
    wait_drained();

    // mixed traffic around small depths
    for (int i = 0; i < 150; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      mixed_op(0);
    end
    wait_drained();

    // fill to capacity with indexed traffic in between
    no_idle = 1'b0;
    while (fill_shadow < CAP) begin
      r = $urandom_range(0, 9);
      if (r < 4) send_op(FN_PUSH_BACK, pick_index(), $urandom());
      else if (r < 8) send_op(FN_PUSH_FRONT, pick_index(), $urandom());
      else if (r == 8) send_op(FN_GET, pick_index(), '0);
      else send_op(FN_SET, pick_index(), $urandom());
    end
    send_op(FN_PUSH_BACK, '0, '1);
    send_op(FN_PUSH_FRONT, '0, '1);
    send_op(FN_GET, '1, '0);
    send_op(FN_SET, '1, '1);
    send_op(FN_GET, '1, '0);
    send_op(FN_GET, '0, '0);
    send_op(FN_PEEK_BACK, '0, '0);
    send_op(FN_PEEK_FRONT, '0, '0);

    // drain heavily from both ends, then start over
    for (int i = 0; i < 60; i++) begin
      if (i % 30 == 0) no_idle = ($urandom_range(0, 2) == 0);
      mixed_op(60);
    end
    send_op(FN_CLEAR, '0, '0);

    while (n_sent < N_ITEMS) begin
      if (n_sent % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      mixed_op(0);
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("ran %0d operations, checked %0d results; store full %0d times, %0d pushes refused",
             sb.n_ops, sb.n_checked, sb.n_full, sb.n_refused);
    $display("%0d indexed accesses out of range, %0d clears, %0d mismatches",
             sb.n_out_of_range, sb.n_clears, sb.n_err);
    if (sb.n_err == 0 && sb.pending() == 0) begin
      $display("** double_ended_indexed_array: PASSED **");
    end else begin
      $display("** double_ended_indexed_array: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout at %0t with %0d results outstanding", $time, sb.pending());
    $display("** double_ended_indexed_array: FAILED **");
    $finish;
  end

endmodule
